/* rtl/assert_macros.svh */
// assertion macros used by the port level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define PTS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("pts assertion failed");

// property checked at every clock edge, reset included
`define PTS_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("pts assertion failed");

`endif

/* rtl/pts_pkg.sv */
// shared types, constants and state codes of the pid tick core
package pts_pkg;

	// payload of one control tick
	typedef struct packed {
		logic [31:0]        time_us;
		logic signed [15:0] sensor_value;
		logic [15:0]        latency_cycles;
	} req_t;

	// result of one control tick
	typedef struct packed {
		logic signed [15:0] drive;
		logic [31:0]        tick_count;
		logic [15:0]        worst_latency;
		logic [31:0]        latency_total;
		logic [31:0]        sequence_checksum;
	} rsp_t;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_VAL_W = 32;

	// register write
	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_VAL_W-1:0] value;
	} cfg_t;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KP        = 3'd0,
		CFG_KI        = 3'd1,
		CFG_KD        = 3'd2,
		CFG_INTEG_LIM = 3'd3,
		CFG_U_LIM     = 3'd4,
		CFG_STEP_MS   = 3'd5,
		CFG_SP_LEVEL  = 3'd6
	} cfg_idx_t;

	// register reset values
	localparam logic [9:0]         KP_RST        = 10'd96;
	localparam logic [9:0]         KI_RST        = 10'd20;
	localparam logic [9:0]         KD_RST        = 10'd24;
	localparam logic [15:0]        INTEG_LIM_RST = 16'd60000;
	localparam logic [14:0]        U_LIM_RST     = 15'd2000;
	localparam logic [22:0]        STEP_MS_RST   = 23'd0;
	localparam logic signed [15:0] SP_LEVEL_RST  = 16'sd1000;

	// shared multiplier operand widths
	localparam int unsigned MUL_A_W = 33;
	localparam int unsigned MUL_B_W = 11;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

	// microseconds per millisecond
	localparam logic signed [MUL_B_W-1:0] US_PER_MS = 11'sd1000;
	// checksum prime 16777619 = 2^24 + 403, low part goes through the multiplier
	localparam logic signed [MUL_B_W-1:0] CK_PRIME_LO = 11'sd403;
	localparam int unsigned CK_PRIME_SH = 24;

	// width of the q8 pid sum
	localparam int unsigned SUM_W = 30;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_TIME,
		S_ERR,
		S_P,
		S_I,
		S_D,
		S_SUM,
		S_CLAMP,
		S_CK,
		S_FIN
	} pts_state_t;

endpackage

/* rtl/pts_chan_if.sv */
// valid/ready channel carrying one payload type
interface pts_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/pts_mul.sv */
// shared signed multiplier with registered product
module pts_mul #(
	parameter int unsigned A_W = 33,
	parameter int unsigned B_W = 11
) (
	input  logic                       clk,
	input  logic signed [A_W-1:0]      a,
	input  logic signed [B_W-1:0]      b,
	output logic signed [A_W+B_W-1:0]  p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule

/* rtl/pid_tick_with_stats_core.sv */
// pid control tick core: sequencer around one shared multiplier, plus statistics
// a tick steps from S_TIME to S_FIN with five passes through the multiplier; S_FIN
// loads the output register once it is free, and a new tick is taken only in S_IDLE;
// the next tick is taken while a result still waits in the output register
// arst_n clears the sequencer, the output valid, all integrator and statistics state,
// and loads the gain and limit registers with their defaults
module pid_tick_with_stats_core (
	input  logic       clk,
	input  logic       arst_n,
	pts_chan_if.sink   req,
	pts_chan_if.source rsp,
	pts_chan_if.sink   cfg
);
	import pts_pkg::*;

	// sequencer
	pts_state_t state_q, state_nxt;
	logic       out_vld_q;
	logic       out_free;
	logic       fin_go;

	// configuration registers
	logic [9:0]         kp_q, ki_q, kd_q;
	logic [15:0]        integ_lim_q;
	logic [14:0]        u_lim_q;
	logic [22:0]        step_ms_q;
	logic signed [15:0] sp_level_q;

	// architectural state
	logic signed [16:0] acc_q;
	logic signed [16:0] prev_q;
	logic [31:0]        tick_q;
	logic [15:0]        peak_q;
	logic [31:0]        lat_tot_q;
	logic [31:0]        ck_q;

	// per tick working registers
	logic [31:0]        time_q;
	logic signed [15:0] sens_q;
	logic [15:0]        lat_q;
	logic signed [16:0] err_q;
	logic signed [16:0] integ_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [15:0] drive_q;
	logic [31:0]        x_q;
	rsp_t               out_q;

	// shared multiplier
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod_q;

	pts_mul #(
		.A_W (MUL_A_W),
		.B_W (MUL_B_W)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	// error and integrator datapath
	logic [MUL_A_W-1:0] step_us;
	logic signed [15:0] sp;
	logic signed [16:0] err_d;
	logic signed [17:0] isum;
	logic signed [17:0] ilim;
	logic signed [17:0] ilim_neg;
	logic signed [16:0] integ_d;
	logic signed [17:0] derr;

	// drive clamp and checksum datapath
	logic signed [SUM_W-9:0] shifted;
	logic signed [SUM_W-9:0] ulim;
	logic signed [SUM_W-9:0] ulim_neg;
	logic signed [15:0] drive_d;
	logic [31:0]        x_d;
	logic [31:0]        ck_d;
	logic [15:0]        peak_d;

	assign out_free = !out_vld_q || rsp.ready;
	assign fin_go   = (state_q == S_FIN) && out_free;

	// config writes are always taken
	assign cfg.ready = 1'b1;

	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE:  if (req.valid) state_nxt = S_TIME;
			S_TIME:  state_nxt = S_ERR;
			S_ERR:   state_nxt = S_P;
			S_P:     state_nxt = S_I;
			S_I:     state_nxt = S_D;
			S_D:     state_nxt = S_SUM;
			S_SUM:   state_nxt = S_CLAMP;
			S_CLAMP: state_nxt = S_CK;
			S_CK:    state_nxt = S_FIN;
			S_FIN:   if (out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// sequencer outputs: input ready and multiplier operand select
	always_comb begin
		req.ready = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			S_IDLE: req.ready = 1'b1;
			// step time in microseconds for the setpoint compare
			S_TIME: begin
				mul_a = {{(MUL_A_W-23){1'b0}}, step_ms_q};
				mul_b = US_PER_MS;
			end
			S_P: begin
				mul_a = {{(MUL_A_W-17){err_q[16]}}, err_q};
				mul_b = {1'b0, kp_q};
			end
			S_I: begin
				mul_a = {{(MUL_A_W-17){integ_q[16]}}, integ_q};
				mul_b = {1'b0, ki_q};
			end
			S_D: begin
				mul_a = {{(MUL_A_W-18){derr[17]}}, derr};
				mul_b = {1'b0, kd_q};
			end
			// low part of the checksum prime, kept on while the result waits
			S_CK, S_FIN: begin
				mul_a = {1'b0, x_q};
				mul_b = CK_PRIME_LO;
			end
			default: ;
		endcase
	end

	// setpoint step: floor(t/1000) >= s is the same as t >= 1000*s
	always_comb begin
		step_us  = prod_q[MUL_A_W-1:0];
		sp       = ({1'b0, time_q} >= step_us) ? sp_level_q : 16'sd0;
		err_d    = {sp[15], sp} - {sens_q[15], sens_q};
		isum     = {acc_q[16], acc_q} + {err_d[16], err_d};
		ilim     = {2'b00, integ_lim_q};
		ilim_neg = -ilim;
		if (isum > ilim) begin
			integ_d = ilim[16:0];
		end else if (isum < ilim_neg) begin
			integ_d = ilim_neg[16:0];
		end else begin
			integ_d = isum[16:0];
		end
		derr = {err_q[16], err_q} - {prev_q[16], prev_q};
	end

	// q8 sum shifted right with floor, then clamped to the drive limit
	always_comb begin
		shifted  = sum_q[SUM_W-1:8];
		ulim     = {{(SUM_W-8-15){1'b0}}, u_lim_q};
		ulim_neg = -ulim;
		if (shifted > ulim) begin
			drive_d = ulim[15:0];
		end else if (shifted < ulim_neg) begin
			drive_d = ulim_neg[15:0];
		end else begin
			drive_d = shifted[15:0];
		end
		x_d = ck_q ^ {{16{drive_d[15]}}, drive_d} ^ {sens_q, 16'h0000};
	end

	// checksum times prime: shifted copy plus product of the low part
	always_comb begin
		ck_d   = {x_q[31-CK_PRIME_SH:0], {CK_PRIME_SH{1'b0}}} + prod_q[31:0];
		peak_d = (lat_q > peak_q) ? lat_q : peak_q;
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_vld_q   <= 1'b0;
			kp_q        <= KP_RST;
			ki_q        <= KI_RST;
			kd_q        <= KD_RST;
			integ_lim_q <= INTEG_LIM_RST;
			u_lim_q     <= U_LIM_RST;
			step_ms_q   <= STEP_MS_RST;
			sp_level_q  <= SP_LEVEL_RST;
			acc_q       <= '0;
			prev_q      <= '0;
			tick_q      <= '0;
			peak_q      <= '0;
			lat_tot_q   <= '0;
			ck_q        <= '0;
		end else begin
			state_q <= state_nxt;

			if (fin_go) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			// register writes, unknown indexes dropped
			if (cfg.valid) begin
				unique case (cfg.data.index)
					CFG_KP:        kp_q        <= cfg.data.value[9:0];
					CFG_KI:        ki_q        <= cfg.data.value[9:0];
					CFG_KD:        kd_q        <= cfg.data.value[9:0];
					CFG_INTEG_LIM: integ_lim_q <= cfg.data.value[15:0];
					CFG_U_LIM:     u_lim_q     <= cfg.data.value[14:0];
					CFG_STEP_MS:   step_ms_q   <= cfg.data.value[22:0];
					CFG_SP_LEVEL:  sp_level_q  <= cfg.data.value[15:0];
					default: ;
				endcase
			end

			// commit the tick
			if (fin_go) begin
				acc_q     <= integ_q;
				prev_q    <= err_q;
				tick_q    <= tick_q + 32'd1;
				peak_q    <= peak_d;
				lat_tot_q <= lat_tot_q + {16'h0000, lat_q};
				ck_q      <= ck_d;
			end
		end
	end

	// working registers and output payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			time_q <= req.data.time_us;
			sens_q <= req.data.sensor_value;
			lat_q  <= req.data.latency_cycles;
		end
		if (state_q == S_ERR) begin
			err_q   <= err_d;
			integ_q <= integ_d;
		end
		// accumulate the three gain products as they come out
		if (state_q == S_I) begin
			sum_q <= prod_q[SUM_W-1:0];
		end else if (state_q == S_D || state_q == S_SUM) begin
			sum_q <= sum_q + prod_q[SUM_W-1:0];
		end
		if (state_q == S_CLAMP) begin
			drive_q <= drive_d;
			x_q     <= x_d;
		end
		if (fin_go) begin
			out_q.drive             <= drive_q;
			out_q.tick_count        <= tick_q + 32'd1;
			out_q.worst_latency     <= peak_d;
			out_q.latency_total     <= lat_tot_q + {16'h0000, lat_q};
			out_q.sequence_checksum <= ck_d;
		end
	end

endmodule

/* rtl/pts_checker.sv */
// port level checks of the pid tick core and their binding
`include "assert_macros.svh"

module pts_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input pts_pkg::rsp_t rsp_data
);
	import pts_pkg::*;

	logic        seen_q;
	logic [31:0] last_tick_q;
	logic [15:0] last_worst_q;

	// last result that went out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			last_tick_q  <= '0;
			last_worst_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			seen_q       <= 1'b1;
			last_tick_q  <= rsp_data.tick_count;
			last_worst_q <= rsp_data.worst_latency;
		end
	end

	`PTS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
	`PTS_ASSERT(a_tick_step, rsp_valid && seen_q |-> rsp_data.tick_count == last_tick_q + 32'd1)
	`PTS_ASSERT(a_worst_mono, rsp_valid && seen_q |-> rsp_data.worst_latency >= last_worst_q)
	`PTS_ASSERT(a_busy_after_take, req_valid && req_ready |=> !req_ready)
	`PTS_ASSERT_ALWAYS(a_rst_quiet, !arst_n |=> !rsp_valid)

endmodule

bind pid_tick_with_stats_core pts_checker u_pts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
